[design/phs_pkg.sv]
// ============================================================================
// phs_pkg
// Shared types and constants for the packet header serializer.
// ============================================================================
package phs_pkg;

    // Header length in bytes for the short and the long header format.
    localparam logic [2:0] HLEN_SHORT = 3'd5;
    localparam logic [2:0] HLEN_LONG  = 3'd6;

    // Largest total packet length that the length byte can carry.
    localparam logic [7:0] TOTAL_MAX = 8'hFF;

    // Checksum base: the folded sum is subtracted from this value.
    localparam logic [10:0] CHK_BASE = 11'h400;

    // Header bytes within the burst.
    localparam int HDR_BYTES = 6;

    // Header fields latched from the first item of a packet.
    typedef struct packed {
        logic [3:0] version;
        logic       long_header;
        logic [2:0] src_dept;
        logic [2:0] dest_dept;
        logic [2:0] hop_count;
        logic [2:0] pkt_kind;
        logic [1:0] ack_bits;
        logic [3:0] src_campus;
        logic [3:0] dest_campus;
    } t_hdr_fields;

    // One input item after unpacking from the stream.
    typedef struct packed {
        t_hdr_fields hdr;
        logic [7:0]  payload_byte;
        logic        has_byte;
        logic        last;
    } t_in_item;

    // Work for the emitter: an optional payload byte, then an optional
    // header burst.
    typedef struct packed {
        logic                          pay_valid;
        logic [7:0]                    pay_offset;
        logic [7:0]                    pay_value;
        logic                          hdr_valid;
        logic                          long_header;
        logic                          dropped;
        logic [HDR_BYTES-1:0][7:0]     hdr_bytes;
    } t_desc;

endpackage

[design/phs_build.sv]
// ============================================================================
// phs_build
// Input register, packet state and checksum; turns each item into a
// descriptor of the result bytes it causes.
// ============================================================================
module phs_build (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  phs_pkg::t_in_item i_item,
    output logic              o_desc_valid,
    input  logic              i_desc_ready,
    output phs_pkg::t_desc    o_desc
);

    // Input register.
    logic              r_item_valid;
    phs_pkg::t_in_item r_item;

    // Packet state.
    logic                 r_in_packet;
    phs_pkg::t_hdr_fields r_hdr;
    logic [7:0]           r_cnt;
    logic [15:0]          r_sum;
    logic                 r_ovf;

    logic                 n_in_packet;
    phs_pkg::t_hdr_fields n_hdr;
    logic [7:0]           n_cnt;
    logic [15:0]          n_sum;
    logic                 n_ovf;

    phs_pkg::t_hdr_fields hf;
    logic [7:0]  cnt0;
    logic [15:0] sum0;
    logic        ovf0;
    logic [2:0]  hlen;
    logic [7:0]  limit;
    logic        take;
    logic [7:0]  total;
    logic [7:0]  b0;
    logic [7:0]  b4;
    logic [7:0]  b5;
    logic [17:0] chk_sum;
    logic [10:0] chk_fold;
    logic [10:0] chk_diff;
    logic [9:0]  chk;
    logic        produces;
    logic        advance;

    // Effective state for the item in the input register; an item that
    // opens a packet starts from a clean slate with its own header fields.
    always_comb begin
        hf   = r_in_packet ? r_hdr : r_item.hdr;
        cnt0 = r_in_packet ? r_cnt : 8'd0;
        sum0 = r_in_packet ? r_sum : 16'd0;
        ovf0 = r_in_packet ? r_ovf : 1'b0;
        hlen = hf.long_header ? phs_pkg::HLEN_LONG : phs_pkg::HLEN_SHORT;
        limit = phs_pkg::TOTAL_MAX - 8'(hlen);
        take = r_item.has_byte && (cnt0 < limit);

        n_cnt = cnt0 + 8'(take);
        n_sum = take ? (sum0 + 16'(r_item.payload_byte)) : sum0;
        n_ovf = ovf0 | (r_item.has_byte & ~take);
    end

    // Header bytes and the folded checksum for the closing item.
    always_comb begin
        total = 8'(hlen) + n_cnt;
        b0 = {hf.version, 1'b0, hlen};
        b4 = {hf.hop_count, hf.pkt_kind, hf.ack_bits};
        b5 = {hf.src_campus, hf.dest_campus};
        chk_sum = 18'(b0) + 18'(total) + 18'({hf.src_dept, hf.dest_dept})
                + 18'(b4) + 18'(n_sum) + (hf.long_header ? 18'(b5) : 18'd0);
        chk_fold = 11'(chk_sum[9:0]) + 11'(chk_sum[17:10]);
        chk_diff = phs_pkg::CHK_BASE - chk_fold;
        chk = chk_diff[9:0];
    end

    // Descriptor toward the emitter.
    always_comb begin
        o_desc.pay_valid    = take;
        o_desc.pay_offset   = 8'(hlen) + cnt0;
        o_desc.pay_value    = r_item.payload_byte;
        o_desc.hdr_valid    = r_item.last;
        o_desc.long_header  = hf.long_header;
        o_desc.dropped      = n_ovf;
        o_desc.hdr_bytes[0] = b0;
        o_desc.hdr_bytes[1] = total;
        o_desc.hdr_bytes[2] = {hf.src_dept, hf.dest_dept, chk[9:8]};
        o_desc.hdr_bytes[3] = chk[7:0];
        o_desc.hdr_bytes[4] = b4;
        o_desc.hdr_bytes[5] = b5;
    end

    // Handshake: an item that causes no result leaves without waiting.
    always_comb begin
        produces     = take | r_item.last;
        o_desc_valid = r_item_valid & produces;
        advance      = r_item_valid & (~produces | i_desc_ready);
        o_ready      = ~r_item_valid | advance;
    end

    // Next packet state; the closing item clears everything.
    always_comb begin
        if (r_item.last) begin
            n_in_packet = 1'b0;
            n_hdr       = '0;
        end else begin
            n_in_packet = 1'b1;
            n_hdr       = hf;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_item_valid <= 1'b1;
        end else if (advance) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    // Packet state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_hdr       <= '0;
            r_cnt       <= 8'd0;
            r_sum       <= 16'd0;
            r_ovf       <= 1'b0;
        end else if (advance) begin
            r_in_packet <= n_in_packet;
            r_hdr       <= n_hdr;
            r_cnt       <= r_item.last ? 8'd0 : n_cnt;
            r_sum       <= r_item.last ? 16'd0 : n_sum;
            r_ovf       <= r_item.last ? 1'b0 : n_ovf;
        end
    end

    // The payload count never passes the limit of the short header.
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (phs_pkg::TOTAL_MAX - 8'(phs_pkg::HLEN_SHORT)))
        else $error("payload count beyond length limit");

    // Outside a packet all running state is clear.
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_packet |-> (r_cnt == 8'd0 && r_sum == 16'd0 && !r_ovf))
        else $error("stale packet state while idle");

endmodule

[design/phs_emit.sv]
// ============================================================================
// phs_emit
// Holds one descriptor and sends its bytes, one per cycle while the output is
// not stalled, through the output register.
// ============================================================================
module phs_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_desc_valid,
    output logic           o_desc_ready,
    input  phs_pkg::t_desc i_desc,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_offset,
    output logic [7:0]     o_value,
    output logic           o_eop,
    output logic           o_dropped
);

    logic           r_desc_valid;
    phs_pkg::t_desc r_desc;
    logic           r_pay_pend;
    logic [2:0]     r_idx;

    logic       r_out_valid;
    logic [7:0] r_out_offset;
    logic [7:0] r_out_value;
    logic       r_out_eop;
    logic       r_out_dropped;

    logic       load_out;
    logic       step;
    logic       hdr_final;
    logic       is_final;
    logic [7:0] cur_offset;
    logic [7:0] cur_value;
    logic       cur_eop;
    logic       cur_dropped;

    // Select the byte to send next: the payload byte first, then the header.
    always_comb begin
        hdr_final = r_desc.long_header ? (r_idx == 3'd5) : (r_idx == 3'd4);
        is_final  = r_pay_pend ? ~r_desc.hdr_valid : hdr_final;
        if (r_pay_pend) begin
            cur_offset  = r_desc.pay_offset;
            cur_value   = r_desc.pay_value;
            cur_eop     = 1'b0;
            cur_dropped = 1'b0;
        end else begin
            cur_offset  = 8'(r_idx);
            cur_value   = r_desc.hdr_bytes[r_idx];
            cur_eop     = hdr_final;
            cur_dropped = r_desc.dropped;
        end
    end

    // Handshake between descriptor slot and output register.
    always_comb begin
        load_out     = ~r_out_valid | i_ready;
        step         = r_desc_valid & load_out;
        o_desc_ready = ~r_desc_valid | (step & is_final);
    end

    // Descriptor slot and byte index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc_valid <= 1'b0;
            r_pay_pend   <= 1'b0;
            r_idx        <= 3'd0;
        end else if (i_desc_valid && o_desc_ready) begin
            r_desc_valid <= 1'b1;
            r_pay_pend   <= i_desc.pay_valid;
            r_idx        <= 3'd0;
        end else if (step && is_final) begin
            r_desc_valid <= 1'b0;
        end else if (step) begin
            if (r_pay_pend) begin
                r_pay_pend <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_desc_valid && o_desc_ready) begin
            r_desc <= i_desc;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_offset  <= cur_offset;
            r_out_value   <= cur_value;
            r_out_eop     <= cur_eop;
            r_out_dropped <= cur_dropped;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_offset  = r_out_offset;
    assign o_value   = r_out_value;
    assign o_eop     = r_out_eop;
    assign o_dropped = r_out_dropped;

    // End of packet only marks the last header byte, offset four or five.
    a_eop_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eop) |->
            (r_out_offset == 8'd4 || r_out_offset == 8'd5))
        else $error("end of packet on a wrong offset");

    // A payload byte never carries the drop flag.
    a_pay_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_eop && r_out_offset >= 8'd5) |-> !r_out_dropped)
        else $error("drop flag on a payload item");

    // A held descriptor with its payload byte gone must still have a header.
    a_desc_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_desc_valid && !r_pay_pend) |-> r_desc.hdr_valid)
        else $error("empty descriptor held");

endmodule

[design/packet_header_serializer_unit.sv]
// A payload byte passes the input register, the descriptor slot and the output
// register; the header burst of 5 or 6 items follows the closing item.
// Throughput: one item per cycle while items carry payload and the master side
// is ready; a closing item holds the emitter for its payload and header bytes.
// Reset: synchronous, active low; clears the open packet and all pending items.
// ============================================================================
// packet_header_serializer_unit
// Serializes packets of a small header format from a stream of items.
// ============================================================================
module packet_header_serializer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] version, [4] long_header, [7:5] src_dept, [10:8] dest_dept,
    // [13:11] hop_count, [16:14] pkt_kind, [18:17] ack_bits,
    // [22:19] src_campus, [26:23] dest_campus, [34:27] payload_byte,
    // [39:35] zero
    input  logic [39:0] s_axis_tdata,
    // [0] has_byte
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] byte_offset, [15:8] byte_value
    output logic [15:0] m_axis_tdata,
    // [0] dropped
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    phs_pkg::t_in_item item;
    phs_pkg::t_desc    desc;
    logic              desc_valid;
    logic              desc_ready;
    logic [7:0]        out_offset;
    logic [7:0]        out_value;

    // Unpack the slave-side item.
    always_comb begin
        item.hdr.version     = s_axis_tdata[3:0];
        item.hdr.long_header = s_axis_tdata[4];
        item.hdr.src_dept    = s_axis_tdata[7:5];
        item.hdr.dest_dept   = s_axis_tdata[10:8];
        item.hdr.hop_count   = s_axis_tdata[13:11];
        item.hdr.pkt_kind    = s_axis_tdata[16:14];
        item.hdr.ack_bits    = s_axis_tdata[18:17];
        item.hdr.src_campus  = s_axis_tdata[22:19];
        item.hdr.dest_campus = s_axis_tdata[26:23];
        item.payload_byte    = s_axis_tdata[34:27];
        item.has_byte        = s_axis_tuser;
        item.last            = s_axis_tlast;
    end

    phs_build u_build (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_item       (item),
        .o_desc_valid (desc_valid),
        .i_desc_ready (desc_ready),
        .o_desc       (desc)
    );

    phs_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (desc_valid),
        .o_desc_ready (desc_ready),
        .i_desc       (desc),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_offset     (out_offset),
        .o_value      (out_value),
        .o_eop        (m_axis_tlast),
        .o_dropped    (m_axis_tuser)
    );

    assign m_axis_tdata = {out_value, out_offset};

endmodule
